// ===== src/byte_alu_with_spill_shift_macros.svh =====
// Assertion macros shared by the byte ALU modules.
// Self-contained; the files that check properties take it in by include.
`ifndef BYTE_ALU_WITH_SPILL_SHIFT_MACROS_SVH
`define BYTE_ALU_WITH_SPILL_SHIFT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge.
`define BAL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, sampled on the rising clock edge.
`define BAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define BAL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BAL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/bal_pkg.sv =====
// Shared command codes, status codes and the pipeline item type of the byte ALU.
// No dependencies.
package bal_pkg;

  localparam int WordBits = 8;

  localparam logic [3:0] CMD_AND = 4'd0;
  localparam logic [3:0] CMD_OR  = 4'd1;
  localparam logic [3:0] CMD_NOT = 4'd2;
  localparam logic [3:0] CMD_NEG = 4'd3;
  localparam logic [3:0] CMD_CMP = 4'd4;
  localparam logic [3:0] CMD_ADD = 4'd5;
  localparam logic [3:0] CMD_INC = 4'd6;
  localparam logic [3:0] CMD_SUB = 4'd7;
  localparam logic [3:0] CMD_MUL = 4'd8;
  localparam logic [3:0] CMD_DIV = 4'd9;
  localparam logic [3:0] CMD_MOD = 4'd10;
  localparam logic [3:0] CMD_SHL = 4'd11;
  localparam logic [3:0] CMD_SHR = 4'd12;
  localparam logic [3:0] CMD_ASR = 4'd13;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CARRY     = 3'd1;
  localparam logic [2:0] ST_BORROW    = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
  localparam logic [2:0] ST_MOD_ZERO  = 3'd4;
  localparam logic [2:0] ST_SHIFT_BIG = 3'd5;
  localparam logic [2:0] ST_ONE_WORD  = 3'd6;
  localparam logic [2:0] ST_TWO_WORD  = 3'd7;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam logic [7:0] MaxShift = 8'd7;

  // One operation in flight: the finished results of the commands done in the first
  // stage plus the partial quotient and remainder of the divider.
  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] res;
    logic [7:0] extra;
    logic [2:0] status;
    logic [1:0] order;
    logic       a_zero;
    logic [7:0] quo;
    logic [7:0] rem;
    logic [7:0] divisor;
  } bal_item_t;

endpackage

// ===== src/bal_front.sv =====
// First pipeline stage of the byte ALU: decodes the command, evaluates the logic,
// add, subtract, multiply and shift commands and seeds the divider. Uses bal_pkg.
module bal_front
  import bal_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] command,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic [7:0] shift_dist,
  input  logic [7:0] spill_in,
  input  logic [7:0] fill_in,
  output logic       out_valid,
  input  logic       out_ready,
  output bal_item_t  out_item
);

  logic              valid;
  bal_item_t         item;
  bal_item_t         item_next;
  logic [8:0]        sum;
  logic [8:0]        diff;
  logic [15:0]       prod;
  logic [7:0]        fill;
  logic [2:0]        n;
  logic [15:0]       left_res;
  logic [15:0]       left_spill;
  logic [15:0]       right_res;
  logic [15:0]       right_spill;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  assign sum  = {1'b0, operand_a} + {1'b0, operand_b};
  assign diff = {1'b0, operand_a} - {1'b0, operand_b};
  assign prod = operand_a * operand_b;
  assign n    = shift_dist[2:0];

  // The arithmetic shift is a right shift whose fill is the sign replicated.
  assign fill = (command == CMD_ASR) ? {WordBits{operand_a[7]}} : fill_in;

  assign left_res    = {operand_a, fill} << n;
  assign left_spill  = {spill_in, operand_a} << n;
  assign right_res   = {fill, operand_a} >> n;
  assign right_spill = {operand_a, spill_in} >> n;

  always_comb begin
    item_next         = '0;
    item_next.cmd     = command;
    item_next.quo     = operand_a;
    item_next.rem     = '0;
    item_next.divisor = operand_b;
    item_next.a_zero  = (operand_a == 8'd0);
    if (operand_a < operand_b) begin
      item_next.order = ORD_LESS;
    end else if (operand_a == operand_b) begin
      item_next.order = ORD_EQUAL;
    end else begin
      item_next.order = ORD_GREATER;
    end
    case (command)
      CMD_AND: item_next.res = operand_a & operand_b;
      CMD_OR:  item_next.res = operand_a | operand_b;
      CMD_NOT: item_next.res = ~operand_a;
      CMD_NEG: item_next.res = 8'd0 - operand_a;
      CMD_ADD: begin
        item_next.res    = sum[7:0];
        item_next.status = sum[8] ? ST_CARRY : ST_OK;
      end
      CMD_INC: begin
        item_next.res    = operand_a + 8'd1;
        item_next.status = (operand_a == 8'hFF) ? ST_CARRY : ST_OK;
      end
      CMD_SUB: begin
        item_next.res    = diff[7:0];
        item_next.status = diff[8] ? ST_BORROW : ST_OK;
      end
      CMD_MUL: begin
        item_next.res    = prod[7:0];
        item_next.extra  = prod[15:8];
        item_next.status = (prod[15:8] == 8'd0) ? ST_ONE_WORD : ST_TWO_WORD;
      end
      CMD_DIV: item_next.status = (operand_b == 8'd0) ? ST_DIV_ZERO : ST_OK;
      CMD_MOD: item_next.status = (operand_b == 8'd0) ? ST_MOD_ZERO : ST_OK;
      CMD_SHL, CMD_SHR, CMD_ASR: begin
        if (shift_dist > MaxShift) begin
          item_next.status = ST_SHIFT_BIG;
          item_next.res    = operand_a;
          item_next.extra  = spill_in;
        end else if (command == CMD_SHL) begin
          item_next.res   = left_res[15:8];
          item_next.extra = left_spill[15:8];
        end else begin
          item_next.res   = right_res[7:0];
          item_next.extra = right_spill[7:0];
        end
      end
      default: item_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

// ===== src/bal_div_half.sv =====
// One registered stage of the restoring divider: four quotient bits per stage.
// Two instances complete an 8-bit divide. Uses bal_pkg and the assertion macros.
`include "byte_alu_with_spill_shift_macros.svh"
module bal_div_half
  import bal_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bal_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output bal_item_t out_item
);

  localparam int Steps = WordBits / 2;

  logic      valid;
  bal_item_t item;
  bal_item_t item_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // Each step brings the next dividend bit into the partial remainder and
  // subtracts the divisor when it fits.
  always_comb begin
    logic [8:0] trial;
    item_next = in_item;
    for (int i = 0; i < Steps; i++) begin
      trial         = {item_next.rem, item_next.quo[7]};
      item_next.quo = {item_next.quo[6:0], 1'b0};
      if (trial >= {1'b0, item_next.divisor}) begin
        trial            = trial - {1'b0, item_next.divisor};
        item_next.quo[0] = 1'b1;
      end
      item_next.rem = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  `BAL_ASSERT_IMPL(rem_below_divisor, clk, rst, valid && (item.divisor != 8'd0), item.rem < item.divisor)
  `BAL_ASSERT_NEXT(take_fills_stage, clk, rst, in_valid && in_ready, valid)

endmodule

// ===== src/byte_alu_with_spill_shift.sv =====
// Top level of the pipelined byte ALU with spill-word shifts.
// Instantiates bal_front and two bal_div_half stages; uses bal_pkg and the macros.
//
// Usage: one request on the slave channel (s_tvalid, s_tready, s_tdata, s_tuser)
// carries a command in s_tuser and its operands in s_tdata. Every request gives
// exactly one result on the master channel (m_tvalid, m_tready, m_tdata), in
// request order.
// The block has four register stages: decode and the commands done at decode
// (including the 8x8 multiply), two divider stages of four quotient bits each,
// and the output register that selects the final fields. A request passes through
// the decode, upper divider, lower divider and output registers in that order.
// Throughput is one request per cycle while m_tready stays high; every command goes
// through the same four stages, and the 8-bit restoring divider sets the stage count.
// Each stage holds while the stage after it is full and not draining, so a
// stall on m_tready fills the pipeline up to four requests before s_tready
// falls; nothing is lost or repeated. Bubbles close up, so a new request is
// taken while a finished result still waits in the output register.
// Reset (rst, synchronous, active high) empties every stage; no result is
// pending afterward and s_tready is high in the following cycle.
`include "byte_alu_with_spill_shift_macros.svh"
module byte_alu_with_spill_shift
  import bal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operand_a, operand_b, shift distance, spill_in, fill_in
  input  logic [3:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // result, extra, status, order, a_is_zero, zero pad
);

  logic      a_valid;
  logic      a_ready;
  bal_item_t a_item;
  logic      b_valid;
  logic      b_ready;
  bal_item_t b_item;
  logic      c_valid;
  logic      c_ready;
  bal_item_t c_item;

  logic       out_valid;
  logic [7:0] out_result;
  logic [7:0] out_extra;
  logic [2:0] out_status;
  logic [1:0] out_order;
  logic       out_a_zero;
  logic [7:0] result_next;
  logic [7:0] extra_next;

  bal_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .command     (s_tuser),
    .operand_a   (s_tdata[7:0]),
    .operand_b   (s_tdata[15:8]),
    .shift_dist  (s_tdata[23:16]),
    .spill_in    (s_tdata[31:24]),
    .fill_in     (s_tdata[39:32]),
    .out_valid   (a_valid),
    .out_ready   (a_ready),
    .out_item    (a_item)
  );

  bal_div_half u_div_hi (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_item   (a_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  bal_div_half u_div_lo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_item   (b_item),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_item  (c_item)
  );

  assign c_ready = !out_valid || m_tready;

  // Divide and modulus take their fields from the divider; a zero divisor
  // keeps the zeros that the first stage left.
  always_comb begin
    result_next = c_item.res;
    extra_next  = c_item.extra;
    if (c_item.divisor != 8'd0) begin
      case (c_item.cmd)
        CMD_DIV: begin
          result_next = c_item.quo;
          extra_next  = c_item.rem;
        end
        CMD_MOD: result_next = c_item.rem;
        default: result_next = c_item.res;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_ready) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && c_valid) begin
      out_result <= result_next;
      out_extra  <= extra_next;
      out_status <= c_item.status;
      out_order  <= c_item.order;
      out_a_zero <= c_item.a_zero;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_a_zero, out_order, out_status, out_extra, out_result};

  `BAL_ASSERT_IMPL(empty_out_takes_input, clk, rst, !out_valid, s_tready)
  `BAL_ASSERT_IMPL(zero_divisor_clears, clk, rst, out_valid && ((out_status == ST_DIV_ZERO) || (out_status == ST_MOD_ZERO)), (out_result == 8'd0) && (out_extra == 8'd0))
  `BAL_ASSERT_IMPL(short_product_high_zero, clk, rst, out_valid && (out_status == ST_ONE_WORD), out_extra == 8'd0)

endmodule
